// ----- rtl/mvpc_pkg.sv -----
// types, codes and constants shared by the valve controller modules
`default_nettype none

package mvpc_pkg;

   typedef enum logic [1:0] {
      OP_SET_TARGET  = 2'd0,
      OP_POSITION    = 2'd1,
      OP_TICK        = 2'd2,
      OP_CLEAR_FAULT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_IDLE       = 2'd0,
      STATUS_MOVING     = 2'd1,
      STATUS_NOT_CLOSED = 2'd2,
      STATUS_FAULT      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_OVERTIME_TICKS     = 3'd0,
      CSR_LIMIT_CLOSE        = 3'd1,
      CSR_LIMIT_OPEN         = 3'd2,
      CSR_DEADBAND_CLOSE     = 3'd3,
      CSR_DEADBAND_OPEN      = 3'd4,
      CSR_DEADBAND_POSITION  = 3'd5,
      CSR_ANTICIPATION_CLOSE = 3'd6,
      CSR_ANTICIPATION_OPEN  = 3'd7
   } csr_index_type;

   localparam logic [13:0] FULL_SCALE = 14'd10000;
   localparam logic [16:0] TICK_MAX   = 17'd65536;

   localparam logic [15:0] OVERTIME_RESET = 16'd600;
   localparam logic [13:0] DEADBAND_RESET = 14'd100;

   // signed width that holds every difference of setpoint, position and margins
   typedef logic signed [17:0] calc_type;

   typedef struct packed {
      logic [15:0] overtime_ticks;
      logic [13:0] limit_close;
      logic [13:0] limit_open;
      logic [13:0] deadband_close;
      logic [13:0] deadband_open;
      logic [13:0] deadband_position;
      logic [13:0] anticipation_close;
      logic [13:0] anticipation_open;
   } cfg_type;

   typedef struct packed {
      logic [13:0]        target_hold;
      logic signed [15:0] position_hold;
      logic               want_open;
      logic               want_close;
      logic               driving_open;
      logic               driving_close;
      logic               open_end;
      logic               close_end;
      logic               position_good;
      logic               fault_latch;
      logic [16:0]        tick_count;
   } state_type;

   typedef struct packed {
      logic        drive_open;
      logic        drive_close;
      status_type  status_code;
      logic        fault;
      logic        in_position;
      logic        at_open_end;
      logic        at_close_end;
      logic [16:0] travel_ticks;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/mvpc_eval.sv -----
// next-state and result logic for one event of the valve controller
`default_nettype none

module mvpc_eval (
   input  mvpc_pkg::cfg_type          cfg,
   input  mvpc_pkg::state_type        cur,
   input  mvpc_pkg::op_type           op,
   input  logic signed [15:0]         target_value,
   input  logic signed [15:0]         measured_value,
   output mvpc_pkg::state_type        nxt,
   output mvpc_pkg::result_type       res
);
   import mvpc_pkg::*;

   state_type  ev;
   logic       do_eval;
   logic       target_ok;
   logic [13:0] sp_new;
   logic signed [15:0] pos_new;
   calc_type   sp;
   calc_type   pos;
   calc_type   err;
   calc_type   err_abs;
   calc_type   open_thr;
   calc_type   close_thr;
   logic       big;
   logic       oe;
   logic       ce;
   logic       wo;
   logic       wc;
   logic       dopen;
   logic       commanding;
   logic [16:0] tc;

   assign target_ok = !target_value[15] && (target_value[14:0] <= {1'b0, FULL_SCALE});

   always_comb begin
      sp_new  = cur.target_hold;
      pos_new = cur.position_hold;
      do_eval = 1'b0;
      unique case (op)
         OP_SET_TARGET: begin
            if (target_ok) begin
               sp_new  = target_value[13:0];
               do_eval = 1'b1;
            end
         end
         OP_POSITION: begin
            pos_new = measured_value;
            do_eval = 1'b1;
         end
         OP_TICK:        ;
         OP_CLEAR_FAULT: ;
         default:        ;
      endcase
   end

   // request and command evaluation on the updated setpoint and position
   always_comb begin
      sp        = calc_type'({4'b0000, sp_new});
      pos       = calc_type'({{2{pos_new[15]}}, pos_new});
      err       = sp - pos;
      err_abs   = err[17] ? -err : err;
      big       = err_abs > calc_type'({4'b0000, cfg.deadband_position});
      open_thr  = calc_type'({4'b0000, cfg.limit_open}) - calc_type'({4'b0000, cfg.deadband_open});
      close_thr = calc_type'({4'b0000, cfg.limit_close})
                  + calc_type'({4'b0000, cfg.deadband_close});
      oe = pos >= open_thr;
      ce = pos <= close_thr;

      wo = cur.want_open;
      wc = cur.want_close;
      if (big && sp > pos) begin
         wo = 1'b1;
         wc = 1'b0;
      end
      if (pos >= sp - calc_type'({4'b0000, cfg.anticipation_open}) || oe) begin
         wo = 1'b0;
      end
      if (big && sp < pos) begin
         wc = 1'b1;
         wo = 1'b0;
      end
      if (pos <= sp + calc_type'({4'b0000, cfg.anticipation_close}) || ce) begin
         wc = 1'b0;
      end
      if (cur.fault_latch) begin
         wo = 1'b0;
         wc = 1'b0;
      end
      // the old close command wins against open, the new open command wins against close
      dopen = !cur.fault_latch && wo && !oe && !cur.driving_close;

      ev               = cur;
      ev.target_hold   = sp_new;
      ev.position_hold = pos_new;
      ev.open_end      = oe;
      ev.close_end     = ce;
      ev.position_good = !big;
      ev.want_open     = wo;
      ev.want_close    = wc;
      ev.driving_open  = dopen;
      ev.driving_close = !cur.fault_latch && wc && !ce && !dopen;
   end

   always_comb begin
      nxt = cur;
      tc  = cur.tick_count;
      unique case (op)
         OP_SET_TARGET: begin
            if (do_eval) begin
               nxt = ev;
            end
         end
         OP_POSITION: begin
            nxt = ev;
         end
         OP_TICK: begin
            if ((cur.driving_open || cur.driving_close) && !cur.position_good
                && tc < TICK_MAX) begin
               tc = tc + 17'd1;
            end
            if (cur.position_good || cur.fault_latch
                || !(cur.driving_open || cur.driving_close)) begin
               tc = '0;
            end
            nxt.tick_count = tc;
            if (tc > {1'b0, cfg.overtime_ticks}) begin
               nxt.fault_latch = 1'b1;
            end
         end
         OP_CLEAR_FAULT: begin
            nxt.fault_latch = 1'b0;
            nxt.tick_count  = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      commanding      = nxt.driving_open || nxt.driving_close;
      res.drive_open  = nxt.driving_open;
      res.drive_close = nxt.driving_close;
      priority if (nxt.fault_latch) begin
         res.status_code = STATUS_FAULT;
      end else if (!nxt.close_end && !commanding) begin
         res.status_code = STATUS_NOT_CLOSED;
      end else if (commanding) begin
         res.status_code = STATUS_MOVING;
      end else begin
         res.status_code = STATUS_IDLE;
      end
      res.fault        = nxt.fault_latch;
      res.in_position  = nxt.position_good;
      res.at_open_end  = nxt.open_end;
      res.at_close_end = nxt.close_end;
      res.travel_ticks = nxt.tick_count;
   end

endmodule

`default_nettype wire

// ----- rtl/motor_valve_position_controller_core.sv -----
// motorized valve position controller: event input register, evaluation, result register
// a taken beat is held in the event register, evaluated from there, and lands in the result
//   register when the event register advances, which raises rsp_valid
// throughput: one beat per cycle unless rsp_stall holds a full pipeline; the event register and result register form a
//   two-entry pipeline, so a held result does not stop the next beat from entering
// reset (synchronous, active high) clears controller state and loads register defaults
`default_nettype none

module motor_valve_position_controller_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [15:0] req_target_value,
   input  logic signed [15:0] req_measured_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_drive_open,
   output logic               rsp_drive_close,
   output logic [1:0]         rsp_status_code,
   output logic               rsp_fault,
   output logic               rsp_in_position,
   output logic               rsp_at_open_end,
   output logic               rsp_at_close_end,
   output logic [16:0]        rsp_travel_ticks,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import mvpc_pkg::*;

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   state_type          state_ff;
   state_type          state_in;
   result_type         res_ff;
   result_type         res_in;
   logic               in_valid_ff;
   logic               in_valid_in;
   op_type             in_op_ff;
   logic signed [15:0] in_target_ff;
   logic signed [15:0] in_measured_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic               advance;
   logic               take;
   logic [13:0]        wdata14;

   assign csr_ready = 1'b1;
   assign wdata14   = csr_wdata[13:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_OVERTIME_TICKS: begin
               if (csr_wdata != 16'd0) begin
                  cfg_in.overtime_ticks = csr_wdata;
               end
            end
            CSR_LIMIT_CLOSE: begin
               if (wdata14 <= FULL_SCALE) begin
                  cfg_in.limit_close = wdata14;
               end
            end
            CSR_LIMIT_OPEN: begin
               if (wdata14 <= FULL_SCALE) begin
                  cfg_in.limit_open = wdata14;
               end
            end
            CSR_DEADBAND_CLOSE:     cfg_in.deadband_close     = wdata14;
            CSR_DEADBAND_OPEN:      cfg_in.deadband_open      = wdata14;
            CSR_DEADBAND_POSITION:  cfg_in.deadband_position  = wdata14;
            CSR_ANTICIPATION_CLOSE: cfg_in.anticipation_close = wdata14;
            CSR_ANTICIPATION_OPEN:  cfg_in.anticipation_open  = wdata14;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.overtime_ticks     <= OVERTIME_RESET;
         cfg_ff.limit_close        <= '0;
         cfg_ff.limit_open         <= FULL_SCALE;
         cfg_ff.deadband_close     <= DEADBAND_RESET;
         cfg_ff.deadband_open      <= DEADBAND_RESET;
         cfg_ff.deadband_position  <= DEADBAND_RESET;
         cfg_ff.anticipation_close <= '0;
         cfg_ff.anticipation_open  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // the event register moves on whenever the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff       <= op_type'(req_operation);
         in_target_ff   <= req_target_value;
         in_measured_ff <= req_measured_value;
      end
   end

   mvpc_eval u_eval (
      .cfg            (cfg_ff),
      .cur            (state_ff),
      .op             (in_op_ff),
      .target_value   (in_target_ff),
      .measured_value (in_measured_ff),
      .nxt            (state_in),
      .res            (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_drive_open   = res_ff.drive_open;
   assign rsp_drive_close  = res_ff.drive_close;
   assign rsp_status_code  = res_ff.status_code;
   assign rsp_fault        = res_ff.fault;
   assign rsp_in_position  = res_ff.in_position;
   assign rsp_at_open_end  = res_ff.at_open_end;
   assign rsp_at_close_end = res_ff.at_close_end;
   assign rsp_travel_ticks = res_ff.travel_ticks;

`ifndef ASSERT_OFF
   a_no_double_drive: assert property (@(posedge clock) disable iff (reset)
      !(state_ff.driving_open && state_ff.driving_close))
      else $error("open and close commanded together");

   a_ticks_saturate: assert property (@(posedge clock) disable iff (reset)
      state_ff.tick_count <= TICK_MAX)
      else $error("travel timer past saturation");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   a_clear_drops_fault: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == OP_CLEAR_FAULT) |=>
      (!state_ff.fault_latch && state_ff.tick_count == '0))
      else $error("fault clear did not reset latch and timer");
`endif

endmodule

`default_nettype wire
